/* design/fepf_pkg.sv */
package fepf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_WIDTH      = 3;
    localparam int MIN_HEIGHT     = 2;
    localparam int CFG_DATA_W     = 11;

    typedef logic [15:0]           pixel_t;
    typedef logic [1:0]            jitter_t;
    typedef logic [4:0]            seed5_t;
    typedef logic [2:0]            seed3_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    localparam cfg_data_t FRAME_WIDTH_RST  = 11'd640;
    localparam cfg_data_t FRAME_HEIGHT_RST = 11'd480;

    localparam jitter_t JITTER_PLUS   = 2'd2;
    localparam seed5_t  SEED_MAX      = 5'd23;
    localparam seed5_t  RED_SEED_BASE = 5'd8;
    localparam seed5_t  RED_MAX       = 5'd31;

    typedef struct packed {
        logic row0;
        logic edge_col;
        logic done;
    } fepf_ctl_t;

endpackage

/* design/fepf_if.sv */
interface fepf_in_if;
    import fepf_pkg::*;
    logic    valid;
    logic    ready;
    pixel_t  pixel_in;
    jitter_t red_jitter;
    seed5_t  seed_red;
    seed5_t  seed_green;
    seed3_t  seed_blue;

    modport source (output valid, pixel_in, red_jitter, seed_red, seed_green, seed_blue,
                    input ready);
    modport sink (input valid, pixel_in, red_jitter, seed_red, seed_green, seed_blue,
                  output ready);
endinterface

interface fepf_out_if;
    import fepf_pkg::*;
    logic   valid;
    logic   ready;
    pixel_t pixel_out;
    logic   frame_done;

    modport source (output valid, pixel_out, frame_done, input ready);
    modport sink (input valid, pixel_out, frame_done, output ready);
endinterface

interface fepf_cfg_if;
    import fepf_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/fepf_line_store.sv */
module fepf_line_store #(
    parameter int DEPTH = fepf_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  fepf_pkg::pixel_t         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output fepf_pkg::pixel_t         rdata_a,
    output fepf_pkg::pixel_t         rdata_b
);
    import fepf_pkg::*;

    pixel_t mem [DEPTH];
    pixel_t rdata_a_reg;
    pixel_t rdata_b_reg;

    // read returns the old entry when the same address is written in that cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* design/fepf_fire_calc.sv */
module fepf_fire_calc (
    input  fepf_pkg::pixel_t    pix,
    input  fepf_pkg::pixel_t    below_left,
    input  fepf_pkg::pixel_t    below_here,
    input  fepf_pkg::pixel_t    below_right,
    input  fepf_pkg::jitter_t   red_jitter,
    input  fepf_pkg::seed5_t    seed_red,
    input  fepf_pkg::seed5_t    seed_green,
    input  fepf_pkg::seed3_t    seed_blue,
    input  fepf_pkg::fepf_ctl_t ctl,
    output fepf_pkg::pixel_t    result
);
    import fepf_pkg::*;

    logic [6:0] rsum;
    logic [6:0] rsum_j;
    logic [7:0] gsum;
    logic [6:0] bsum;
    jitter_t    jit;
    logic [4:0] red_sh;
    logic [4:0] red;
    seed5_t     sr_sat;
    seed5_t     sg_sat;
    pixel_t     fire_pix;
    pixel_t     seed_pix;

    always_comb
    begin
        rsum = 7'(pix[15:11]) + 7'(below_left[15:11])
             + 7'(below_here[15:11]) + 7'(below_right[15:11]);
        gsum = 8'(pix[10:5]) + 8'(below_left[10:5])
             + 8'(below_here[10:5]) + 8'(below_right[10:5]);
        bsum = 7'(pix[4:0]) + 7'(below_left[4:0])
             + 7'(below_here[4:0]) + 7'(below_right[4:0]);

        // code three acts as plus one
        jit = (red_jitter > JITTER_PLUS) ? JITTER_PLUS : red_jitter;
        // rsum_j carries the jittered sum plus one, so zero means minus one
        rsum_j = rsum + 7'(jit);
        red_sh = 5'((rsum_j - 7'd1) >> 2);
        red    = (rsum_j == 7'd0 || red_sh == RED_MAX) ? 5'd0 : red_sh;

        fire_pix = {red, gsum[7:2], bsum[6:2]};

        sr_sat   = (seed_red > SEED_MAX) ? SEED_MAX : seed_red;
        sg_sat   = (seed_green > SEED_MAX) ? SEED_MAX : seed_green;
        seed_pix = {5'(sr_sat + RED_SEED_BASE), 1'b0, sg_sat, 2'b00, seed_blue};

        if (ctl.row0)
        begin
            result = seed_pix;
        end
        else if (ctl.edge_col)
        begin
            result = pix;
        end
        else
        begin
            result = fire_pix;
        end
    end

endmodule

/* design/fire_effect_pixel_filter.sv */
// Pipeline: accepted pixels pass through stage one, then the output register.
// Throughput: one pixel per cycle unless the output stalls; each transaction does two reads
//   and one write of the line store in its acceptance cycle, so the store's ports set the rate.
// Reset: counters and neighbour register clear, the frame size returns to 640 by 480;
//   the line store is not cleared and holds undefined data until a first row passes.
module fire_effect_pixel_filter #(
    parameter int MAX_WIDTH  = fepf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fepf_pkg::MAX_HEIGHT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    fepf_in_if.sink     pixel_src,
    fepf_out_if.source  pixel_dst,
    fepf_cfg_if.sink    cfg
);
    import fepf_pkg::*;

    localparam int CNTW  = $clog2(MAX_WIDTH);
    localparam int RCNTW = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CWW   = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int CHW   = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

    cfg_data_t        frame_width_reg;
    cfg_data_t        frame_height_reg;
    logic [CNTW-1:0]  col_count_reg;
    logic [CNTW-1:0]  col_count_next;
    logic [RCNTW-1:0] row_count_reg;
    logic [RCNTW-1:0] row_count_next;
    pixel_t           left_reg;

    logic [CWW-1:0]   w_ext;
    logic [CHW-1:0]   h_ext;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [CNTW-1:0]  w_last;
    logic [RCNTW-1:0] h_last;
    logic [CNTW-1:0]  col;
    logic             last_col;
    logic             last_row;

    logic             src_rdy;
    logic             src_fire;
    logic             s1_adv;

    logic             s1_valid_reg;
    pixel_t           s1_pixel_reg;
    jitter_t          s1_jitter_reg;
    seed5_t           s1_seed_red_reg;
    seed5_t           s1_seed_green_reg;
    seed3_t           s1_seed_blue_reg;
    fepf_ctl_t        s1_ctl_reg;
    fepf_ctl_t        ctl_next;

    logic             out_valid_reg;
    pixel_t           out_pixel_reg;
    logic             out_done_reg;

    pixel_t           below_here;
    pixel_t           below_right;
    pixel_t           calc_result;

    // clamp the frame size, locate the current column and form the next counts and control flags
    always_comb
    begin
        w_ext = CWW'(frame_width_reg);
        h_ext = CHW'(frame_height_reg);
        if (w_ext < CWW'(MIN_WIDTH))
        begin
            w_eff = WW'(MIN_WIDTH);
        end
        else if (w_ext > CWW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(w_ext);
        end
        if (h_ext < CHW'(MIN_HEIGHT))
        begin
            h_eff = HW'(MIN_HEIGHT);
        end
        else if (h_ext > CHW'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(h_ext);
        end
        w_last = CNTW'(w_eff - WW'(1));
        h_last = RCNTW'(h_eff - HW'(1));

        last_col = (col_count_reg >= w_last);
        last_row = (row_count_reg >= h_last);
        col      = last_col ? w_last : col_count_reg;

        ctl_next.row0     = (row_count_reg == '0);
        ctl_next.edge_col = (col == '0) || last_col;
        ctl_next.done     = last_col && last_row;

        if (last_col)
        begin
            col_count_next = '0;
            row_count_next = last_row ? '0 : row_count_reg + RCNTW'(1);
        end
        else
        begin
            col_count_next = col + CNTW'(1);
            row_count_next = row_count_reg;
        end
    end

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || pixel_dst.ready);
    assign src_rdy  = !s1_valid_reg || s1_adv;
    assign src_fire = pixel_src.valid && src_rdy;

    assign pixel_src.ready = src_rdy;
    assign cfg.ready       = 1'b1;

    fepf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .we      (src_fire),
        .waddr   (col),
        .wdata   (pixel_src.pixel_in),
        .re      (src_fire),
        .raddr_a (col),
        .raddr_b (CNTW'(col + CNTW'(1))),
        .rdata_a (below_here),
        .rdata_b (below_right)
    );

    fepf_fire_calc u_fire_calc (
        .pix         (s1_pixel_reg),
        .below_left  (left_reg),
        .below_here  (below_here),
        .below_right (below_right),
        .red_jitter  (s1_jitter_reg),
        .seed_red    (s1_seed_red_reg),
        .seed_green  (s1_seed_green_reg),
        .seed_blue   (s1_seed_blue_reg),
        .ctl         (s1_ctl_reg),
        .result      (calc_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            left_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (src_fire)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
            // the centre pixel below becomes the left neighbour of the next transaction
            if (s1_adv)
            begin
                left_reg <= below_here;
            end
            if (src_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_dst.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_fire)
        begin
            s1_pixel_reg      <= pixel_src.pixel_in;
            s1_jitter_reg     <= pixel_src.red_jitter;
            s1_seed_red_reg   <= pixel_src.seed_red;
            s1_seed_green_reg <= pixel_src.seed_green;
            s1_seed_blue_reg  <= pixel_src.seed_blue;
            s1_ctl_reg        <= ctl_next;
        end
        if (s1_adv)
        begin
            out_pixel_reg <= calc_result;
            out_done_reg  <= s1_ctl_reg.done;
        end
    end

    assign pixel_dst.valid      = out_valid_reg;
    assign pixel_dst.pixel_out  = out_pixel_reg;
    assign pixel_dst.frame_done = out_done_reg;

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        src_fire && last_col |=> col_count_reg == '0)
        else $error("column count did not wrap after last column");

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_fire && !last_col |=> row_count_reg == $past(row_count_reg))
        else $error("row count moved inside a row");

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced transaction missing from output register");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !pixel_dst.ready |-> !pixel_src.ready)
        else $error("input accepted while both stages are full and stalled");

endmodule
